FILE: sv/assert_macros.svh
// assertion macros for the escaper rtl
// no dependencies; included by modules that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define U2NE_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define U2NE_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define U2NE_ASSERT(name, clk, rst_n, prop, msg)

`define U2NE_ASSERT_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

FILE: sv/u2ne_pkg.sv
// shared types, character codes and digit split for the escaper
// no dependencies
package u2ne_pkg;

  localparam int unsigned U2NE_QDEPTH = 2;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_Q     = 8'h71;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_O     = 8'h6f;
  localparam logic [7:0] CH_T     = 8'h74;

  localparam logic [2:0] STEP_AMP  = 3'd0;
  localparam logic [2:0] STEP_HASH = 3'd1;
  localparam logic [2:0] STEP_HUND = 3'd2;
  localparam logic [2:0] STEP_TENS = 3'd3;
  localparam logic [2:0] STEP_ONES = 3'd4;
  localparam logic [2:0] STEP_SEMI = 3'd5;

  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_LEAD,
    PEND_AMP
  } pend_e;

  typedef enum logic [1:0] {
    SEG_CHAR,
    SEG_QUOT,
    SEG_ENT
  } seg_kind_e;

  typedef struct packed {
    seg_kind_e  kind;
    logic [7:0] chr;
    logic [1:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
    logic       has_h;
    logic       has_t;
  } seg_t;

  typedef struct packed {
    seg_t seg0;
    seg_t seg1;
    logic two_seg;
    logic last;
  } cmd_t;

  function automatic seg_t char_seg(input logic [7:0] c);
    seg_t s;
    s       = '0;
    s.kind  = SEG_CHAR;
    s.chr   = c;
    return s;
  endfunction

  function automatic seg_t quot_seg();
    seg_t s;
    s      = '0;
    s.kind = SEG_QUOT;
    return s;
  endfunction

  // decimal split of an 8-bit code point, tens by reciprocal multiply
  function automatic seg_t ent_seg(input logic [7:0] v);
    seg_t        s;
    logic [1:0]  h;
    logic [7:0]  r;
    logic [14:0] p;
    logic [3:0]  t;
    logic [7:0]  t10;
    logic [7:0]  o;
    s = '0;
    if (v >= 8'd200) begin
      h = 2'd2;
      r = v - 8'd200;
    end else if (v >= 8'd100) begin
      h = 2'd1;
      r = v - 8'd100;
    end else begin
      h = 2'd0;
      r = v;
    end
    p       = 15'(r[6:0]) * 15'd205;
    t       = p[14:11];
    t10     = {1'b0, t, 3'b000} + {3'b000, t, 1'b0};
    o       = r - t10;
    s.kind  = SEG_ENT;
    s.hund  = h;
    s.tens  = t;
    s.ones  = o[3:0];
    s.has_h = (v >= 8'd100);
    s.has_t = (v >= 8'd10);
    return s;
  endfunction

endpackage

FILE: sv/u2ne_front.sv
// front end: config register, held byte state, classification into commands
// depends on u2ne_pkg
module u2ne_front import u2ne_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output cmd_t       q_cmd_o
);

  logic       quotes_ok_q;
  pend_e      pend_q, pend_d;
  logic [1:0] lead_q, lead_d;
  logic       accept;
  logic       a_vld, b_vld;
  seg_t       seg_a, seg_b, ent_calc;
  logic [7:0] ent_v;

  assign accept   = in_valid_i && !q_full_i;
  assign ent_v    = (pend_q == PEND_LEAD) ? {lead_q, in_byte_i[5:0]}
                                          : {in_byte_i[1:0], 6'd0};
  assign ent_calc = ent_seg(ent_v);

  always_comb begin
    a_vld  = 1'b0;
    seg_a  = ent_seg(8'd38);
    b_vld  = 1'b1;
    seg_b  = char_seg(in_byte_i);
    pend_d = PEND_NONE;
    lead_d = 2'd0;
    case (pend_q)
      PEND_LEAD: begin
        seg_b = ent_calc;
      end
      PEND_NONE, PEND_AMP: begin
        if (pend_q == PEND_AMP) begin
          a_vld = 1'b1;
          if (in_byte_i == CH_HASH) seg_a = char_seg(CH_AMP);
        end
        if (in_byte_i[7]) begin
          if (in_last_i) begin
            seg_b = ent_calc;
          end else begin
            b_vld  = 1'b0;
            pend_d = PEND_LEAD;
            lead_d = in_byte_i[1:0];
          end
        end else if (!quotes_ok_q && in_byte_i == CH_QUOTE) begin
          seg_b = quot_seg();
        end else if (!quotes_ok_q && in_byte_i == CH_AMP) begin
          if (in_last_i) begin
            seg_b = ent_seg(8'd38);
          end else begin
            b_vld  = 1'b0;
            pend_d = PEND_AMP;
          end
        end
      end
      default: begin
        seg_b = char_seg(in_byte_i);
      end
    endcase
  end

  always_comb begin
    q_cmd_o.last = in_last_i;
    if (a_vld) begin
      q_cmd_o.seg0    = seg_a;
      q_cmd_o.seg1    = seg_b;
      q_cmd_o.two_seg = b_vld;
    end else begin
      q_cmd_o.seg0    = seg_b;
      q_cmd_o.seg1    = seg_b;
      q_cmd_o.two_seg = 1'b0;
    end
  end

  assign q_push_o = accept && (a_vld || b_vld);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quotes_ok_q <= 1'b0;
      pend_q      <= PEND_NONE;
      lead_q      <= 2'd0;
    end else begin
      if (cfg_we_i) quotes_ok_q <= cfg_wdata_i;
      if (accept) begin
        pend_q <= pend_d;
        lead_q <= lead_d;
      end
    end
  end

endmodule

FILE: sv/u2ne_cmd_fifo.sv
// short command queue between front and back ends
// depends on u2ne_pkg
module u2ne_cmd_fifo import u2ne_pkg::*; #(
  parameter int unsigned Depth = U2NE_QDEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t data_o,
  output logic valid_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
      if (do_pop)  rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

FILE: sv/u2ne_back.sv
// back end: expands commands into characters, output register with empty/pop
// depends on u2ne_pkg and assert_macros.svh
`include "assert_macros.svh"
module u2ne_back import u2ne_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  cmd_t       q_cmd_i,
  output logic       q_pop_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] out_char_o,
  output logic       run_last_o,
  output logic       string_end_o
);

  logic       sel_q, sel_d;
  logic [2:0] step_q, step_d;
  logic       out_valid_q;
  logic [7:0] out_char_q;
  logic       run_last_q;
  logic       string_end_q;
  logic       adv;
  seg_t       seg;
  logic [7:0] chr;
  logic       seg_done;
  logic       cmd_done;
  logic [2:0] step_nx;

  assign adv = q_valid_i && (!out_valid_q || pop_i);
  assign seg = sel_q ? q_cmd_i.seg1 : q_cmd_i.seg0;

  always_comb begin
    chr      = seg.chr;
    seg_done = 1'b1;
    step_nx  = step_q + 3'd1;
    case (seg.kind)
      SEG_CHAR: begin
        chr = seg.chr;
      end
      SEG_QUOT: begin
        seg_done = (step_q == STEP_SEMI);
        case (step_q)
          3'd0:    chr = CH_AMP;
          3'd1:    chr = CH_Q;
          3'd2:    chr = CH_U;
          3'd3:    chr = CH_O;
          3'd4:    chr = CH_T;
          default: chr = CH_SEMI;
        endcase
      end
      SEG_ENT: begin
        seg_done = (step_q == STEP_SEMI);
        if (step_q == STEP_HASH) begin
          step_nx = seg.has_h ? STEP_HUND : (seg.has_t ? STEP_TENS : STEP_ONES);
        end
        case (step_q)
          STEP_AMP:  chr = CH_AMP;
          STEP_HASH: chr = CH_HASH;
          STEP_HUND: chr = CH_ZERO | {6'd0, seg.hund};
          STEP_TENS: chr = CH_ZERO | {4'd0, seg.tens};
          STEP_ONES: chr = CH_ZERO | {4'd0, seg.ones};
          default:   chr = CH_SEMI;
        endcase
      end
      default: begin
        chr = seg.chr;
      end
    endcase
  end

  assign cmd_done = seg_done && (sel_q || !q_cmd_i.two_seg);
  assign q_pop_o  = adv && cmd_done;

  always_comb begin
    sel_d  = sel_q;
    step_d = step_q;
    if (adv) begin
      if (seg_done) begin
        step_d = STEP_AMP;
        sel_d  = !cmd_done;
      end else begin
        step_d = step_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= 1'b0;
      step_q      <= STEP_AMP;
      out_valid_q <= 1'b0;
    end else begin
      sel_q  <= sel_d;
      step_q <= step_d;
      if (adv)        out_valid_q <= 1'b1;
      else if (pop_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_char_q   <= chr;
      run_last_q   <= cmd_done;
      string_end_q <= cmd_done && q_cmd_i.last;
    end
  end

  assign empty_o      = !out_valid_q;
  assign out_char_o   = out_char_q;
  assign run_last_o   = run_last_q;
  assign string_end_o = string_end_q;

  `U2NE_ASSERT(a_end_is_run_last, clk_i, rst_ni, (out_valid_q && string_end_q) |-> run_last_q, "string end without run last")
  `U2NE_ASSERT(a_step_range, clk_i, rst_ni, step_q <= STEP_SEMI, "sequencer step out of range")
  `U2NE_ASSERT(a_pop_whole_cmd, clk_i, rst_ni, q_pop_o |-> (sel_q || !q_cmd_i.two_seg), "command popped before its second segment")
  `U2NE_ASSERT_NEVER(a_second_only_if_two, clk_i, rst_ni, q_valid_i && sel_q && !q_cmd_i.two_seg, "second segment selected on single-segment command")

endmodule

FILE: sv/utf8_to_numeric_entity_escaper.sv
// top level of the utf-8 to numeric character reference escaper
// depends on u2ne_pkg, u2ne_front, u2ne_cmd_fifo, u2ne_back
//
// channel   direction  handshake               word
// input     in         push / full             in_byte_i, in_last_i
// result    out        empty / pop             out_char_o, run_last_o, string_end_o
// config    in         cfg_we_i                cfg_wdata_i (quotes_ok)
//
// one result character per cycle while commands are queued and pop does not stall;
// a byte yields 1 character for plain text, up to 11, set by the back-end sequencer
// a byte that is only held for lookahead produces nothing
// a command is queued for the byte, then each character is registered for output
// full rises when the command queue (QDepth entries) is full; pop stalls hold the
// output register and back-pressure the queue; reset clears held state at once
module utf8_to_numeric_entity_escaper import u2ne_pkg::*; #(
  parameter int unsigned QDepth = U2NE_QDEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char_o,
  output logic       run_last_o,
  output logic       string_end_o
);

  logic q_push, q_full, q_pop, q_valid;
  cmd_t q_wcmd, q_rcmd;

  assign full = q_full;

  u2ne_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (push),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_wcmd)
  );

  u2ne_cmd_fifo #(
    .Depth(QDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wcmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_rcmd),
    .valid_o(q_valid)
  );

  u2ne_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_rcmd),
    .q_pop_o     (q_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_char_o  (out_char_o),
    .run_last_o  (run_last_o),
    .string_end_o(string_end_o)
  );

endmodule

FILE: tb/sv/utf8_to_numeric_entity_escaper_test.sv
// self-checking testbench for utf8_to_numeric_entity_escaper: directed and random byte
// strings, a predictor of the escaped text, and a checker on every popped word
// depends on u2ne_pkg and the escaper rtl
module utf8_to_numeric_entity_escaper_test import u2ne_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned LONG_HOLD    = 200;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned RANDOM_ITEMS = 60;

  typedef struct packed {
    logic [7:0] chr;
    logic       run_end;
    logic       str_end;
  } escaped_word_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic       cfg_wdata;
  logic       push;
  logic       full;
  logic [7:0] in_byte;
  logic       in_last;
  logic       empty;
  logic       pop;
  logic [7:0] out_char;
  logic       run_last;
  logic       string_end;

  // predictor state
  logic          keep_quotes;
  pend_e         held_kind;
  logic [1:0]    held_lead;
  logic [7:0]    step_chars[$];
  escaped_word_t escaped_words[$];

  bit          tx_gaps_on;
  bit          rx_stalls_on;
  bit          long_hold_req;
  int unsigned stall_left;
  int unsigned fail_count;
  int unsigned cycle_count;

  utf8_to_numeric_entity_escaper DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .push         (push),
    .full         (full),
    .in_byte_i    (in_byte),
    .in_last_i    (in_last),
    .empty        (empty),
    .pop          (pop),
    .out_char_o   (out_char),
    .run_last_o   (run_last),
    .string_end_o (string_end)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------- predictor ----------------

  function automatic void add_ref(input logic [7:0] v);
    step_chars.push_back(CH_AMP);
    step_chars.push_back(CH_HASH);
    if (v >= 8'd100) step_chars.push_back(CH_ZERO + v / 8'd100);
    if (v >= 8'd10) step_chars.push_back(CH_ZERO + (v / 8'd10) % 8'd10);
    step_chars.push_back(CH_ZERO + v % 8'd10);
    step_chars.push_back(CH_SEMI);
  endfunction

  function automatic void add_quot();
    step_chars.push_back(CH_AMP);
    step_chars.push_back(CH_Q);
    step_chars.push_back(CH_U);
    step_chars.push_back(CH_O);
    step_chars.push_back(CH_T);
    step_chars.push_back(CH_SEMI);
  endfunction

  function automatic void escape_byte(input logic [7:0] b, input logic last);
    escaped_word_t w;
    step_chars.delete();
    if (held_kind == PEND_LEAD) begin
      held_kind = PEND_NONE;
      add_ref({held_lead, b[5:0]});
      held_lead = '0;
    end else begin
      // a held ampersand stays plain only in front of a hash
      if (held_kind == PEND_AMP) begin
        if (b == CH_HASH) step_chars.push_back(CH_AMP);
        else add_ref(CH_AMP);
      end
      held_kind = PEND_NONE;
      if (b[7]) begin
        if (last) begin
          add_ref({b[1:0], 6'd0});
        end else begin
          held_kind = PEND_LEAD;
          held_lead = b[1:0];
        end
      end else if (!keep_quotes && b == CH_QUOTE) begin
        add_quot();
      end else if (!keep_quotes && b == CH_AMP) begin
        if (last) add_ref(CH_AMP);
        else held_kind = PEND_AMP;
      end else begin
        step_chars.push_back(b);
      end
    end
    foreach (step_chars[k]) begin
      w.chr     = step_chars[k];
      w.run_end = (k == step_chars.size() - 1);
      w.str_end = w.run_end && last;
      escaped_words.push_back(w);
    end
  endfunction

  // ---------------- result side ----------------

  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk_i) begin
    if (long_hold_req) begin
      stall_left    = LONG_HOLD;
      long_hold_req = 1'b0;
    end
    if (stall_left > 0) begin
      pop = 1'b0;
      stall_left--;
    end else if (rx_stalls_on && $urandom_range(0, 99) < 25) begin
      stall_left = pick_idle();
      pop        = (stall_left == 0);
    end else begin
      pop = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    escaped_word_t e;
    if (rst_ni && pop && !empty) begin
      if (escaped_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, got char %02h run_last %0b end %0b",
                 $time, out_char, run_last, string_end);
        fail_count++;
      end else begin
        e = escaped_words.pop_front();
        if (out_char !== e.chr) begin
          $display("%0t: out_char expected %02h got %02h", $time, e.chr, out_char);
          fail_count++;
        end
        if (run_last !== e.run_end) begin
          $display("%0t: run_last expected %0b got %0b", $time, e.run_end, run_last);
          fail_count++;
        end
        if (string_end !== e.str_end) begin
          $display("%0t: string_end expected %0b got %0b", $time, e.str_end, string_end);
          fail_count++;
        end
      end
    end
  end

  // ---------------- input side ----------------

  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = tx_gaps_on ? pick_idle() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push    = 1'b1;
    in_byte = b;
    in_last = last;
    do @(posedge clk_i); while (full);
    escape_byte(b, last);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    push = 1'b0;
    while (escaped_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_quotes_ok(input logic v);
    wait_drained();
    // held bytes produce nothing, so let the pipe settle
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    keep_quotes = v;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // ---------------- tests ----------------

  task automatic test_plain_text();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h41, 1'b1);
  endtask

  task automatic test_quote_escapes();
    send_byte(CH_QUOTE, 1'b0);
    send_byte(CH_AMP, 1'b0);
    send_byte(CH_HASH, 1'b0);
    send_byte(CH_AMP, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(CH_AMP, 1'b1);
  endtask

  task automatic test_two_byte_refs();
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'h4a, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h09, 1'b0);
    send_byte(8'hc0, 1'b0);
    send_byte(CH_QUOTE, 1'b1);
    send_byte(8'h82, 1'b1);
  endtask

  task automatic test_quote_setting();
    write_quotes_ok(1'b1);
    send_byte(CH_QUOTE, 1'b0);
    send_byte(CH_AMP, 1'b0);
    send_byte(8'he2, 1'b0);
    send_byte(CH_QUOTE, 1'b1);
    // ampersand held across a setting change still resolves as escaped
    write_quotes_ok(1'b0);
    send_byte(CH_AMP, 1'b0);
    write_quotes_ok(1'b1);
    send_byte(8'h62, 1'b1);
    write_quotes_ok(1'b0);
  endtask

  function automatic void build_string(ref logic [7:0] text[$]);
    int unsigned len;
    int unsigned kind;
    text.delete();
    len = $urandom_range(1, 8);
    while (text.size() < len) begin
      kind = $urandom_range(0, 19);
      if (kind < 8) text.push_back(8'($urandom_range(8'h20, 8'h7e)));
      else if (kind < 10) text.push_back(CH_QUOTE);
      else if (kind < 12) text.push_back(CH_AMP);
      else if (kind < 13) text.push_back(CH_HASH);
      else if (kind < 16) begin
        text.push_back(8'($urandom_range(8'hc0, 8'hff)));
        text.push_back(8'h80 | 8'($urandom_range(0, 63)));
      end else if (kind < 17) text.push_back(8'($urandom_range(8'h80, 8'hff)));
      else if (kind < 18) text.push_back(8'($urandom_range(8'h00, 8'h1f)));
      else text.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic test_random_strings();
    logic [7:0]  text[$];
    int unsigned sent;
    bit          open_end;
    sent = 0;
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      build_string(text);
      // now and then a string runs on without its end flag
      open_end = ($urandom_range(0, 9) == 0);
      foreach (text[k]) begin
        send_byte(text[k], (k == text.size() - 1) && !open_end);
        sent++;
      end
      if ($urandom_range(0, 3) == 0) write_quotes_ok(1'($urandom_range(0, 1)));
    end
    send_byte(8'h2e, 1'b1);
  endtask

  task automatic test_full_backpressure();
    logic [7:0] text[$];
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    wait_drained();
    long_hold_req = 1'b1;
    repeat (4) begin
      build_string(text);
      foreach (text[k]) send_byte(text[k], k == text.size() - 1);
    end
    send_byte(8'hd5, 1'b0);
    send_byte(8'hbf, 1'b1);
  endtask

  task automatic test_drain_pause();
    logic [7:0] text[$];
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    repeat (3) begin
      build_string(text);
      foreach (text[k]) send_byte(text[k], k == text.size() - 1);
      wait_drained();
    end
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = 1'b0;
    push          = 1'b0;
    pop           = 1'b0;
    in_byte       = '0;
    in_last       = 1'b0;
    keep_quotes   = 1'b0;
    held_kind     = PEND_NONE;
    held_lead     = '0;
    tx_gaps_on    = 1'b0;
    rx_stalls_on  = 1'b0;
    long_hold_req = 1'b0;
    stall_left    = 0;
    fail_count    = 0;
    cycle_count   = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_plain_text();
    test_quote_escapes();
    test_two_byte_refs();
    test_quote_setting();
    test_random_strings();
    test_full_backpressure();
    test_drain_pause();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/u2ne_pkg.sv
sv/u2ne_front.sv
sv/u2ne_cmd_fifo.sv
sv/u2ne_back.sv
sv/utf8_to_numeric_entity_escaper.sv
tb/sv/utf8_to_numeric_entity_escaper_test.sv
